// ----- design/scanline_polygon_span_fill_macros.svh -----
// assertion macros for the span fill block
`ifndef SCANLINE_POLYGON_SPAN_FILL_MACROS_SVH
`define SCANLINE_POLYGON_SPAN_FILL_MACROS_SVH
// implication checked at every clock edge outside reset
`define SPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked on the next clock edge
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/spf_pkg.sv -----
`timescale 1ns / 1ps
package spf_pkg;
  localparam int MaxVerts   = 64;
  localparam int FracBits   = 8;
  localparam int MaxResults = 32;
  localparam int VIdxW      = 6;
  localparam int VCntW      = 7;
  localparam int XingW      = 18;
  localparam int CoordW     = 10;
  localparam int QuotW      = 30;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_ROW    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [CoordW-1:0] vert_x;
    logic [CoordW-1:0] vert_y;
    logic [CoordW-1:0] row;
  } spf_in_t;

  typedef struct packed {
    logic [XingW-1:0]  span_start;
    logic [XingW-1:0]  span_end;
    logic [CoordW-1:0] span_row;
    logic              span_valid;
    logic              last;
  } spf_out_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load_in;     // capture item, reset edge index
    logic vert_wr;     // write vertex at count
    logic cnt_clr;
    logic rd_a;        // read vertex e
    logic rd_b;        // read vertex e+1 (wrapping)
    logic cap_a;
    logic cap_b;
    logic edge_eval;   // decide crossing, start divider
    logic div_step;
    logic xing_store;  // write crossing, bump n, next edge
    logic edge_next;   // skip edge
    logic sort_init;
    logic sort_rd;     // read list[j-1]
    logic sort_cmp;    // compare/shift
    logic sort_next_i;
    logic emit_init;
    logic emit_rd0;
    logic emit_rd1;
    logic emit_out;
    logic emit_empty;
  } spf_cmd_t;

  typedef struct packed {
    logic edges_done;
    logic crosses;
    logic div_done;
    logic sort_done;   // i >= n
    logic shift_more;  // j>0 and list[j-1]>key (after read)
    logic j_zero;
    logic no_spans;
    logic emit_last;
  } spf_stat_t;
endpackage

// ----- design/spf_ram.sv -----
`timescale 1ns / 1ps
module spf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- design/spf_datapath.sv -----
`timescale 1ns / 1ps
module spf_datapath import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  spf_in_t   din,
  input  spf_cmd_t  cmd,
  output spf_stat_t stat,
  output spf_out_t  dout
);
  spf_in_t          item;
  logic [VCntW-1:0] vcount;
  logic [VCntW-1:0] e;
  logic [VCntW-1:0] n;
  logic [VCntW-1:0] si;
  logic [VCntW-1:0] sj;
  logic [XingW-1:0] key;
  logic [VCntW-1:0] k;
  logic [VCntW-1:0] spans;
  logic [CoordW-1:0] ax, ay, bx, by;

  // vertex memories
  logic [VIdxW-1:0]  v_raddr;
  logic [CoordW-1:0] vx_rd, vy_rd;
  logic [VCntW-1:0]  e_inc;
  assign e_inc = e + 1'b1;
  always_comb begin
    if (cmd.rd_b) v_raddr = (e_inc < vcount) ? e_inc[VIdxW-1:0] : '0;
    else          v_raddr = e[VIdxW-1:0];
  end
  spf_ram #(.Width(CoordW), .Depth(MaxVerts)) u_vx (
    .clk, .we(cmd.vert_wr), .waddr(vcount[VIdxW-1:0]), .wdata(item.vert_x),
    .raddr(v_raddr), .rdata(vx_rd));
  spf_ram #(.Width(CoordW), .Depth(MaxVerts)) u_vy (
    .clk, .we(cmd.vert_wr), .waddr(vcount[VIdxW-1:0]), .wdata(item.vert_y),
    .raddr(v_raddr), .rdata(vy_rd));

  // crossing list memory
  logic             x_we;
  logic [VIdxW-1:0] x_waddr, x_raddr;
  logic [XingW-1:0] x_wdata, x_rd;
  spf_ram #(.Width(XingW), .Depth(MaxVerts)) u_xl (
    .clk, .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rd));

  // edge geometry
  logic              y_lo_a;
  logic [CoordW-1:0] lo, hi;
  logic              sgn;
  logic [CoordW:0]   adx, ady, adr;
  assign y_lo_a = ay < by;
  assign lo = y_lo_a ? ay : by;
  assign hi = y_lo_a ? by : ay;
  assign stat.crosses = (lo != hi) && (item.row >= lo) && (item.row < hi);

  // restoring divider: |dr*dx|<<8 / |dy|
  logic [QuotW-1:0]   dividend, quot;
  logic [CoordW-1:0]  divisor;
  logic [CoordW:0]    rem;
  logic [4:0]         dcnt;
  logic               neg;
  logic [2*CoordW+1:0] prod;
  logic [CoordW:0]    rem_sh, rem_sub;
  assign rem_sh  = {rem[CoordW-1:0], dividend[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign stat.div_done = (dcnt == 5'd0);
  always_comb begin
    adx = (bx >= ax) ? {1'b0, bx - ax} : {1'b0, ax - bx};
    ady = (by >= ay) ? {1'b0, by - ay} : {1'b0, ay - by};
    adr = (item.row >= ay) ? {1'b0, item.row - ay} : {1'b0, ay - item.row};
    sgn = (bx < ax) ^ (by < ay) ^ (item.row < ay);
  end

  // crossing value
  logic signed [XingW+3:0] v;
  logic [XingW-1:0] xing;
  always_comb begin
    v = $signed({4'd0, ax, {FracBits{1'b0}}})
      + (neg ? -$signed({2'b0, quot[XingW+1:0]}) : $signed({2'b0, quot[XingW+1:0]}));
    xing = v[XingW+3] ? '0 : v[XingW-1:0];
  end

  always_comb begin
    x_we    = 1'b0;
    x_waddr = n[VIdxW-1:0];
    x_wdata = xing;
    x_raddr = '0;
    if (cmd.xing_store) x_we = 1'b1;
    if (cmd.sort_cmp && sj != '0 && x_rd > key) begin
      x_we = 1'b1; x_waddr = sj[VIdxW-1:0]; x_wdata = x_rd;
    end else if (cmd.sort_cmp) begin
      x_we = 1'b1; x_waddr = sj[VIdxW-1:0]; x_wdata = key;
    end
    if (cmd.sort_init || cmd.sort_next_i) x_raddr = si[VIdxW-1:0];
    if (cmd.sort_rd) x_raddr = sj[VIdxW-1:0] - 1'b1;
    if (cmd.emit_rd0) x_raddr = {k[VIdxW-2:0], 1'b0};
    if (cmd.emit_rd1) x_raddr = {k[VIdxW-2:0], 1'b1};
  end

  assign stat.edges_done = (e >= vcount);
  assign stat.sort_done  = (si >= n);
  assign stat.j_zero     = (sj == '0);
  assign stat.shift_more = (sj != '0) && (x_rd > key);
  assign stat.no_spans   = (spans == '0);
  assign stat.emit_last  = (k + 1'b1 == spans);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
    end else begin
      if (cmd.load_in) begin item <= din; e <= '0; n <= '0; end
      if (cmd.vert_wr) vcount <= vcount + 1'b1;
      if (cmd.cnt_clr) vcount <= '0;
      if (cmd.cap_a) begin ax <= vx_rd; ay <= vy_rd; end
      if (cmd.cap_b) begin bx <= vx_rd; by <= vy_rd; end
      if (cmd.edge_eval) begin
        prod     <= adr * adx;
        divisor  <= ady[CoordW-1:0];
        neg      <= sgn;
        dcnt     <= 5'(QuotW + 1);
        rem      <= '0;
        quot     <= '0;
      end
      if (cmd.div_step) begin
        if (dcnt == 5'(QuotW + 1)) begin
          dividend <= {prod[QuotW-FracBits-1:0], {FracBits{1'b0}}};
        end else begin
          dividend <= dividend << 1;
          if (!rem_sub[CoordW]) begin
            rem  <= rem_sub; quot <= {quot[QuotW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;  quot <= {quot[QuotW-2:0], 1'b0};
          end
        end
        dcnt <= dcnt - 1'b1;
      end
      if (cmd.xing_store) begin n <= n + 1'b1; e <= e + 1'b1; end
      if (cmd.edge_next) e <= e + 1'b1;
      if (cmd.sort_init) si <= 7'd1;
      if (cmd.sort_init || cmd.sort_next_i) begin sj <= si; end
      if (cmd.sort_rd && sj == si) key <= x_rd;
      if (cmd.sort_cmp) begin
        if (stat.shift_more) sj <= sj - 1'b1;
        else si <= si + 1'b1;
      end
      if (cmd.emit_init) begin
        k <= '0;
        spans <= ((n >> 1) > VCntW'(MaxResults)) ? VCntW'(MaxResults) : (n >> 1);
      end
      if (cmd.emit_rd1) dout.span_start <= x_rd;
      if (cmd.emit_out) begin
        dout.span_end   <= x_rd;
        dout.span_row   <= item.row;
        dout.span_valid <= 1'b1;
        dout.last       <= stat.emit_last;
        k <= k + 1'b1;
      end
      if (cmd.emit_empty) begin
        dout <= '{span_start: '0, span_end: '0, span_row: item.row,
                  span_valid: 1'b0, last: 1'b1};
      end
    end
  end
endmodule

// ----- design/spf_ctrl.sv -----
`timescale 1ns / 1ps
module spf_ctrl import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [1:0] action,
  input  spf_stat_t stat,
  input  logic      vert_full,
  output spf_cmd_t  cmd,
  output logic      busy,
  output logic      done
);
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_EDGE, S_RDA, S_RDB, S_CAPB, S_EVAL, S_DIV, S_STORE,
    S_SORT, S_SKEY, S_SKEY2, S_SRD, S_SCMP, S_EMIT, S_ERD0, S_ERD1,
    S_EOUT, S_EOUT2, S_DONE
  } state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:     cmd.load_in = start;
      S_DISPATCH: begin
        cmd.vert_wr = (action == ACT_APPEND) && !vert_full;
        cmd.cnt_clr = (action == ACT_CLEAR);
      end
      S_EDGE:  cmd.rd_a = 1'b1;
      S_RDA:   begin cmd.rd_b = 1'b1; cmd.cap_a = 1'b1; end
      S_RDB:   cmd.rd_b = 1'b1;
      S_CAPB:  cmd.cap_b = 1'b1;
      S_EVAL:  begin
        cmd.edge_eval = stat.crosses;
        cmd.edge_next = !stat.crosses;
      end
      S_DIV:   cmd.div_step = !stat.div_done;
      S_STORE: cmd.xing_store = 1'b1;
      S_SORT:  cmd.sort_init = 1'b1;
      S_SKEY:  cmd.sort_next_i = !stat.sort_done;
      S_SKEY2: cmd.sort_rd = 1'b1;
      S_SRD:   cmd.sort_rd = 1'b1;
      S_SCMP:  cmd.sort_cmp = 1'b1;
      S_EMIT:  cmd.emit_init = 1'b1;
      S_ERD0:  begin cmd.emit_rd0 = !stat.no_spans; cmd.emit_empty = stat.no_spans; end
      S_ERD1:  cmd.emit_rd1 = 1'b1;
      S_EOUT:  cmd.emit_out = 1'b1;
      S_EOUT2: cmd.emit_rd0 = 1'b0;
      S_DONE:  cmd.emit_rd0 = 1'b0;
      default: cmd = '0;
    endcase
  end

  // key read shares the sort_rd path: sj == si at first read of an insertion pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin state <= S_DISPATCH; busy <= 1'b1; end
        S_DISPATCH: begin
          if (action == ACT_ROW) state <= S_EDGE;
          else begin state <= S_IDLE; busy <= 1'b0; end
        end
        S_EDGE:  state <= stat.edges_done ? S_SORT : S_RDA;
        S_RDA:   state <= S_RDB;
        S_RDB:   state <= S_CAPB;
        S_CAPB:  state <= S_EVAL;
        S_EVAL:  state <= stat.crosses ? S_DIV : S_EDGE;
        S_DIV:   if (stat.div_done) state <= S_STORE;
        S_STORE: state <= S_EDGE;
        S_SORT:  state <= S_SKEY;
        S_SKEY:  state <= stat.sort_done ? S_EMIT : S_SKEY2;
        S_SKEY2: state <= S_SCMP;
        S_SRD:   state <= S_SCMP;
        S_SCMP:  state <= stat.shift_more ? S_SRD : S_SKEY;
        S_EMIT:  state <= S_ERD0;
        S_ERD0:  if (stat.no_spans) begin
          done <= 1'b1; state <= S_DONE;
        end else state <= S_ERD1;
        S_ERD1:  state <= S_EOUT;
        S_EOUT:  begin
          done <= 1'b1;
          state <= stat.emit_last ? S_DONE : S_EOUT2;
        end
        S_EOUT2: state <= S_ERD0;
        S_DONE:  begin state <= S_IDLE; busy <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- design/scanline_polygon_span_fill.sv -----
`timescale 1ns / 1ps
// steps: append/clear/unused pass dispatch and return to idle; a row reads each
// edge, runs the divider and a store per crossing edge, insertion sorts the list
// (key read, then read and compare per shift) and emits spans or one empty row
// throughput: one transaction at a time, busy stays high until a row's last result
// reset: synchronous active-high rst empties the vertex table; ram contents stay
// results come one per strobe and the receiver cannot stall them
module scanline_polygon_span_fill import spf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  spf_in_t  in_item,
  output logic     busy,
  output logic     result_valid,
  output spf_out_t result
);
  spf_cmd_t  cmd;
  spf_stat_t stat;
  spf_in_t   held;
  logic      full;
  logic [VCntW-1:0] cnt;

  // capture the command so the dispatch step sees a stable action
  always_ff @(posedge clk) begin
    if (start && !busy) held <= in_item;
  end

  // vertex count mirror for the table full test
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else if (cmd.vert_wr) cnt <= cnt + 1'b1;
    else if (cmd.cnt_clr) cnt <= '0;
  end
  assign full = (cnt == VCntW'(MaxVerts));

  spf_ctrl u_ctrl (
    .clk, .rst, .start, .action(held.action), .stat, .vert_full(full),
    .cmd, .busy, .done(result_valid));

  spf_datapath u_dp (
    .clk, .rst, .din(in_item), .cmd, .stat, .dout(result));
endmodule

// ----- design/spf_checker.sv -----
`timescale 1ns / 1ps
`include "scanline_polygon_span_fill_macros.svh"
module spf_checker import spf_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     result_valid,
  input spf_out_t result
);
  `SPF_ASSERT_IMPL(a_res_busy, result_valid, busy)
  `SPF_ASSERT_NEXT(a_take, start && !busy, busy)
  `SPF_ASSERT_IMPL(a_empty_last, result_valid && !result.span_valid, result.last)
  `SPF_ASSERT_NEXT(a_last_end, result_valid && result.last, !result_valid)
endmodule
bind scanline_polygon_span_fill spf_checker u_chk (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import spf_pkg::*;

  logic     clk;
  logic     rst;
  logic     start;
  spf_in_t  in_item;
  logic     busy;
  logic     result_valid;
  spf_out_t result;

  scanline_polygon_span_fill dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .result_valid(result_valid), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the vertex table
  logic [CoordW-1:0] poly_x [MaxVerts];
  logic [CoordW-1:0] poly_y [MaxVerts];
  int                poly_cnt;
  spf_out_t          span_queue[$];
  int                fail_cnt;

  // one row item in the directed table may carry a typed-in expectation
  typedef struct {
    spf_in_t  item;
    bit       has_exp;
    spf_out_t exp_span;
  } dir_row_t;

  task automatic report_mismatch(input string what);
    fail_cnt++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // crossing of one edge with the row, 8 fraction bits, truncated toward zero
  function automatic logic [XingW-1:0] edge_x(input int ax, ay, bx, by, r);
    longint dx, dy, dr, q, v;
    dx = bx - ax;
    dy = by - ay;
    dr = r - ay;
    q = (dr * dx * (64'sd1 <<< FracBits)) / dy;
    v = longint'(ax) * (64'sd1 <<< FracBits) + q;
    if (v < 0) v = 0;
    return v[XingW-1:0];
  endfunction

  // update the table and queue the spans each transaction should produce
  task automatic predict_spans(input spf_in_t it);
    logic [XingW-1:0] xs[$];
    logic [XingW-1:0] key;
    spf_out_t o;
    int f, lo, hi, j, nspan;
    case (it.action)
      ACT_APPEND: begin
        if (poly_cnt < MaxVerts) begin
          poly_x[poly_cnt] = it.vert_x;
          poly_y[poly_cnt] = it.vert_y;
          poly_cnt++;
        end
      end
      ACT_CLEAR: poly_cnt = 0;
      ACT_ROW: begin
        for (int e = 0; e < poly_cnt; e++) begin
          f = (e + 1 < poly_cnt) ? e + 1 : 0;
          lo = (poly_y[e] < poly_y[f]) ? int'(poly_y[e]) : int'(poly_y[f]);
          hi = (poly_y[e] < poly_y[f]) ? int'(poly_y[f]) : int'(poly_y[e]);
          if (lo == hi || int'(it.row) < lo || int'(it.row) >= hi) continue;
          xs.push_back(edge_x(int'(poly_x[e]), int'(poly_y[e]), int'(poly_x[f]),
                              int'(poly_y[f]), int'(it.row)));
        end
        // insertion sort, same order as the hardware
        for (int i = 1; i < xs.size(); i++) begin
          key = xs[i];
          j = i;
          while (j > 0 && xs[j-1] > key) begin
            xs[j] = xs[j-1];
            j--;
          end
          xs[j] = key;
        end
        nspan = xs.size() / 2;
        if (nspan > MaxResults) nspan = MaxResults;
        if (nspan == 0) begin
          o = '0;
          o.span_row = it.row;
          o.last = 1'b1;
          span_queue.push_back(o);
        end
        for (int k = 0; k < nspan; k++) begin
          o.span_start = xs[2*k];
          o.span_end   = xs[2*k+1];
          o.span_row   = it.row;
          o.span_valid = 1'b1;
          o.last       = (k + 1 == nspan);
          span_queue.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  // result checker: every strobe pops the oldest expected span
  always @(posedge clk) begin
    spf_out_t want;
    if (!rst && result_valid) begin
      if (span_queue.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = span_queue.pop_front();
        if (result.span_start !== want.span_start)
          report_mismatch($sformatf("span_start %0h want %0h", result.span_start,
                                    want.span_start));
        if (result.span_end !== want.span_end)
          report_mismatch($sformatf("span_end %0h want %0h", result.span_end,
                                    want.span_end));
        if (result.span_row !== want.span_row)
          report_mismatch($sformatf("span_row %0d want %0d", result.span_row,
                                    want.span_row));
        if (result.span_valid !== want.span_valid)
          report_mismatch("span_valid");
        if (result.last !== want.last)
          report_mismatch("last");
      end
    end
  end

  // send one transaction; start is left high, and the task returns at an edge that sees busy low
  task automatic send_item(input spf_in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_spans(it);
  endtask

  // start drops only when there is a real gap
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic spf_in_t mk(input logic [1:0] a, input int x, y, r);
    spf_in_t t;
    t.action = a;
    t.vert_x = CoordW'(x);
    t.vert_y = CoordW'(y);
    t.row    = CoordW'(r);
    return t;
  endfunction

  function automatic spf_out_t empty_row(input int r);
    spf_out_t o;
    o = '0;
    o.span_row = CoordW'(r);
    o.last = 1'b1;
    return o;
  endfunction

  dir_row_t dir_tab[$];

  initial begin
    spf_in_t it;
    int      mode, nv, cx, cy, rad;
    rst      = 1'b1;
    start    = 1'b0;
    in_item  = '0;
    fail_cnt = 0;
    poly_cnt = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: empty table, extremes, vertical edge, degenerate shapes,
    // unused action code, clear
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 0), 1, empty_row(0)});
    dir_tab.push_back('{mk(ACT_APPEND, 1023, 1023, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 1023), 1, empty_row(1023)});
    dir_tab.push_back('{mk(ACT_APPEND, 0, 0, 1023), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 512), 0, '0});
    dir_tab.push_back('{mk(ACT_APPEND, 0, 1023, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 1022), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 1023), 1, empty_row(1023)});
    dir_tab.push_back('{mk(2'd3, 1023, 1023, 1023), 0, '0});
    dir_tab.push_back('{mk(ACT_CLEAR, 0, 0, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 5), 1, empty_row(5)});
    // concave shape with rows through and between its vertices
    dir_tab.push_back('{mk(ACT_APPEND, 10, 10, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_APPEND, 100, 50, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_APPEND, 200, 10, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_APPEND, 200, 90, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_APPEND, 10, 90, 0), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 10), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 33), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 50), 0, '0});
    dir_tab.push_back('{mk(ACT_ROW, 0, 0, 89), 0, '0});
    dir_tab.push_back('{mk(ACT_CLEAR, 0, 0, 0), 0, '0});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].has_exp) begin
        send_item(dir_tab[i].item);
        if (span_queue.size() == 0 ||
            span_queue[span_queue.size()-1] !== dir_tab[i].exp_span)
          report_mismatch($sformatf("directed row %0d prediction", i));
      end else begin
        send_item(dir_tab[i].item);
      end
      idle_gap();
    end

    // random polygons with rows inside them, plus noise
    for (int p = 0; p < 7; p++) begin
      send_item(mk(ACT_CLEAR, $urandom, $urandom, $urandom));
      mode = $urandom_range(0, 9);
      if (mode == 0) nv = $urandom_range(62, 70);      // near or past the table's 64 entries
      else if (mode == 1) nv = $urandom_range(1, 2);
      else nv = $urandom_range(3, 12);
      cx = $urandom_range(0, 1023);
      cy = $urandom_range(0, 1023);
      rad = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(4, 200);
      for (int v = 0; v < nv; v++) begin
        if ($urandom_range(0, 3) == 0) begin
          it = mk(ACT_APPEND, $urandom, $urandom, $urandom);
        end else begin
          it = mk(ACT_APPEND, 0, 0, $urandom);
          it.vert_x = CoordW'((cx + $urandom_range(0, rad)) % 1024);
          it.vert_y = CoordW'((cy + $urandom_range(0, rad)) % 1024);
        end
        send_item(it);
        idle_gap();
      end
      for (int r = 0; r < 6; r++) begin
        it = mk(ACT_ROW, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) != 0) it.row = CoordW'((cy + $urandom_range(0, rad)) % 1024);
        if ($urandom_range(0, 15) == 0) it.action = 2'd3;
        send_item(it);
        idle_gap();
      end
    end

    start <= 1'b0;
    while (span_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[scanline_polygon_span_fill] OK");
    end else begin
      $display("[scanline_polygon_span_fill] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("[scanline_polygon_span_fill] ERROR");
    $finish;
  end
endmodule
